### rtl/pdrs_pkg.sv
// ----------------------------------------------------------------------------
// Priority decode request scheduler package
// Shared types, queue geometry and codes for the scheduler modules.
// ----------------------------------------------------------------------------
package pdrs_pkg;

	localparam int NUM_Q  = 4;
	localparam int SLOTS  = 12;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 5;

	// Queue depths and slot bases in the shared entry array
	localparam logic [CNT_W-1:0]  Q_DEPTH [NUM_Q] = '{5'd1, 5'd2, 5'd8, 5'd1};
	localparam logic [SLOT_W-1:0] Q_BASE  [NUM_Q] = '{4'd0, 4'd1, 4'd3, 4'd11};

	localparam logic [1:0] Q_EXACT    = 2'd0;
	localparam logic [1:0] Q_PREFETCH = 2'd2;
	localparam logic [1:0] Q_LAST_CTX = 2'd2;
	localparam logic [1:0] Q_ANALYSIS = 2'd3;

	typedef enum logic [1:0] {
		OP_SUBMIT   = 2'd0,
		OP_TAKE     = 2'd1,
		OP_CANCEL   = 2'd2,
		OP_SHUTDOWN = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_ACCEPTED   = 3'd0,
		K_REJECTED   = 3'd1,
		K_SUPERSEDED = 3'd2,
		K_DISPATCHED = 3'd3,
		K_NOTHING    = 3'd4,
		K_DONE       = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		QOP_NONE,
		QOP_POP,
		QOP_PUSH,
		QOP_ROTATE
	} qop_t;

	typedef struct packed {
		logic [31:0] frame;
		logic [15:0] sess;
		logic [15:0] epoch;
		logic [31:0] gen;
		logic        has_ctx;
		logic        seq;
	} entry_t;

	typedef struct packed {
		qop_t       qop;
		logic [1:0] q;
		entry_t     wdata;
	} store_ctl_t;

	typedef struct packed {
		entry_t                       head;
		logic [NUM_Q-1:0][CNT_W-1:0]  count;
	} store_stat_t;

endpackage

### rtl/pdrs_if.sv
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdrs_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [1:0]  priority_req;
	logic [31:0] frame_id;
	logic        frame_valid;
	logic        token_present;
	logic        sequential_mode;
	logic        has_context;
	logic [15:0] session_id;
	logic [15:0] session_epoch;
	logic [31:0] generation;

	modport source (output valid, op, priority_req, frame_id, frame_valid, token_present,
		sequential_mode, has_context, session_id, session_epoch, generation, input ready);
	modport sink (input valid, op, priority_req, frame_id, frame_valid, token_present,
		sequential_mode, has_context, session_id, session_epoch, generation, output ready);
endinterface

interface pdrs_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] job_frame;
	logic [1:0]  job_priority;
	logic        job_sequential;
	logic        last;

	modport source (output valid, kind, job_frame, job_priority, job_sequential, last,
		input ready);
	modport sink (input valid, kind, job_frame, job_priority, job_sequential, last,
		output ready);
endinterface

### rtl/priority_decode_request_scheduler_top.sv
// A take is answered from the registered response slot in the cycle after it
// is accepted. Cancel all and shutdown walk every queued job and every queue.
// Submit walks the scanned entries queue by queue; the sequencer walks the
// shared entry array one entry at a time, and a stalled response holds the
// walk where an entry must be answered.
// Reset (arst_n low) empties all queues, clears the stop flag and latest context.
// ----------------------------------------------------------------------------
// Priority decode request scheduler
// Four priority job queues with context supersession, served by a sequencer.
// ----------------------------------------------------------------------------
module priority_decode_request_scheduler_top (
	input  logic       clk,
	input  logic       arst_n,
	pdrs_req_if.sink   req,
	pdrs_rsp_if.source rsp
);
	import pdrs_pkg::*;

	store_ctl_t  ctl;
	store_stat_t stat;

	pdrs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ctl    (ctl),
		.stat   (stat)
	);

	pdrs_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat)
	);

endmodule

### rtl/pdrs_store.sv
// ----------------------------------------------------------------------------
// Scheduler queue store
// Four circular queues in one entry array; pop, push and rotate of one queue.
// ----------------------------------------------------------------------------
module pdrs_store (
	input  logic               clk,
	input  logic               arst_n,
	input  pdrs_pkg::store_ctl_t ctl,
	output pdrs_pkg::store_stat_t stat
);
	import pdrs_pkg::*;

	entry_t                        mem_q [SLOTS];
	logic [NUM_Q-1:0][SLOT_W-1:0]  head_q;
	logic [NUM_Q-1:0][CNT_W-1:0]   cnt_q;

	logic [CNT_W-1:0]  depth;
	logic [CNT_W-1:0]  head_ext;
	logic [CNT_W-1:0]  tail_sum;
	logic [CNT_W-1:0]  tail_idx;
	logic [CNT_W-1:0]  head_inc;
	logic [SLOT_W-1:0] head_nxt;
	logic [SLOT_W-1:0] head_addr;
	logic [SLOT_W-1:0] tail_addr;

	// Locate head and tail of the selected queue
	always_comb begin
		depth     = Q_DEPTH[ctl.q];
		head_ext  = {1'b0, head_q[ctl.q]};
		tail_sum  = head_ext + cnt_q[ctl.q];
		tail_idx  = (tail_sum >= depth) ? tail_sum - depth : tail_sum;
		head_inc  = head_ext + 5'd1;
		head_nxt  = (head_inc == depth) ? '0 : head_inc[SLOT_W-1:0];
		head_addr = Q_BASE[ctl.q] + head_q[ctl.q];
		tail_addr = Q_BASE[ctl.q] + tail_idx[SLOT_W-1:0];
	end

	assign stat.head  = mem_q[head_addr];
	assign stat.count = cnt_q;

	// Write the tail on push and rotate
	always_ff @(posedge clk) begin
		if (ctl.qop == QOP_PUSH || ctl.qop == QOP_ROTATE) begin
			mem_q[tail_addr] <= (ctl.qop == QOP_PUSH) ? ctl.wdata : mem_q[head_addr];
		end
	end

	// Advance pointers and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			unique case (ctl.qop)
				QOP_POP: begin
					head_q[ctl.q] <= head_nxt;
					cnt_q[ctl.q]  <= cnt_q[ctl.q] - 5'd1;
				end
				QOP_PUSH: cnt_q[ctl.q] <= cnt_q[ctl.q] + 5'd1;
				QOP_ROTATE: head_q[ctl.q] <= head_nxt;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.qop == QOP_PUSH |-> cnt_q[ctl.q] < Q_DEPTH[ctl.q])
		else $error("push into a full queue");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.qop == QOP_POP || ctl.qop == QOP_ROTATE) |-> cnt_q[ctl.q] != '0)
		else $error("pop from an empty queue");
	a_rotate_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.qop == QOP_ROTATE |=> $stable(cnt_q))
		else $error("rotate changed a count");
`endif

endmodule

### rtl/pdrs_seq.sv
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Walks entries one per cycle, held while a response waits, for scan, flush,
// drop and cancel; one shared generation comparator; registered response slot.
// ----------------------------------------------------------------------------
module pdrs_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	pdrs_req_if.sink              req,
	pdrs_rsp_if.source            rsp,
	output pdrs_pkg::store_ctl_t  ctl,
	input  pdrs_pkg::store_stat_t stat
);
	import pdrs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_FLUSH, S_DROP, S_PUSH, S_CLEAR, S_DONE
	} state_t;

	state_t           state_q, state_d;
	logic [1:0]       qsel_q, qsel_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic             stopped_q, stopped_d;
	logic             lat_valid_q, lat_valid_d;
	logic [15:0]      lat_sess_q, lat_sess_d;
	logic [15:0]      lat_epoch_q, lat_epoch_d;
	logic [31:0]      lat_gen_q, lat_gen_d;
	entry_t           new_q, new_d;
	logic [1:0]       prio_q, prio_d;

	logic             out_valid_q;
	kind_t            out_kind_q;
	logic [31:0]      out_frame_q;
	logic [1:0]       out_prio_q;
	logic             out_seq_q;
	logic             out_last_q;

	logic             emit;
	kind_t            e_kind;
	logic [31:0]      e_frame;
	logic [1:0]       e_prio;
	logic             e_seq;
	logic             e_last;

	logic             out_free;
	logic             fire;
	logic [31:0]      cmp_gen;
	logic             gen_lt;
	logic             gen_eq;
	logic             same;
	logic             reject;
	logic             new_latest;
	logic             stale;
	logic             any_job;
	logic [1:0]       take_q;
	logic [1:0]       qnext;
	entry_t           in_entry;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign fire      = req.valid && req.ready;

	// Shared generation comparator
	assign cmp_gen = (state_q == S_SCAN) ? stat.head.gen : req.generation;
	assign gen_lt  = cmp_gen < lat_gen_q;
	assign gen_eq  = cmp_gen == lat_gen_q;

	assign same = lat_valid_q && req.session_id == lat_sess_q
		&& req.session_epoch == lat_epoch_q;
	assign reject = !req.token_present || !req.frame_valid || stopped_q
		|| (req.has_context && same && gen_lt);
	assign new_latest = req.has_context && (!lat_valid_q || (same && !gen_lt && !gen_eq));
	assign stale = stat.head.has_ctx && stat.head.sess == lat_sess_q
		&& stat.head.epoch == lat_epoch_q && gen_lt;
	assign qnext = qsel_q + 2'd1;

	// Pick the highest-priority nonempty queue
	always_comb begin
		any_job = 1'b1;
		priority if (stat.count[0] != '0) take_q = 2'd0;
		else if (stat.count[1] != '0) take_q = 2'd1;
		else if (stat.count[2] != '0) take_q = 2'd2;
		else begin
			take_q  = Q_ANALYSIS;
			any_job = stat.count[3] != '0;
		end
	end

	always_comb begin
		in_entry.frame   = req.frame_id;
		in_entry.sess    = req.has_context ? req.session_id : 16'd0;
		in_entry.epoch   = req.has_context ? req.session_epoch : 16'd0;
		in_entry.gen     = req.has_context ? req.generation : 32'd0;
		in_entry.has_ctx = req.has_context;
		in_entry.seq     = req.sequential_mode;
	end

	// Sequence one item
	always_comb begin
		state_d     = state_q;
		qsel_d      = qsel_q;
		rem_d       = rem_q;
		stopped_d   = stopped_q;
		lat_valid_d = lat_valid_q;
		lat_sess_d  = lat_sess_q;
		lat_epoch_d = lat_epoch_q;
		lat_gen_d   = lat_gen_q;
		new_d       = new_q;
		prio_d      = prio_q;
		emit        = 1'b0;
		e_kind      = K_DONE;
		e_frame     = '0;
		e_prio      = '0;
		e_seq       = 1'b0;
		e_last      = 1'b1;
		ctl.qop     = QOP_NONE;
		ctl.q       = qsel_q;
		ctl.wdata   = new_q;

		unique case (state_q)
			S_IDLE: begin
				ctl.q = take_q;
				if (fire) begin
					unique case (op_t'(req.op))
						OP_SUBMIT: begin
							new_d  = in_entry;
							prio_d = req.priority_req;
							if (reject) begin
								emit   = 1'b1;
								e_kind = K_REJECTED;
							end else if (new_latest) begin
								lat_valid_d = 1'b1;
								lat_sess_d  = req.session_id;
								lat_epoch_d = req.session_epoch;
								lat_gen_d   = req.generation;
								qsel_d      = Q_EXACT;
								rem_d       = stat.count[0];
								state_d     = S_SCAN;
							end else begin
								state_d = S_FLUSH;
							end
						end
						OP_TAKE: begin
							emit = 1'b1;
							if (any_job) begin
								ctl.qop = QOP_POP;
								e_kind  = K_DISPATCHED;
								e_frame = stat.head.frame;
								e_prio  = take_q;
								e_seq   = stat.head.seq;
							end else begin
								e_kind = K_NOTHING;
							end
						end
						default: begin
							if (stopped_q) begin
								emit = 1'b1;
							end else begin
								stopped_d = stopped_q || (op_t'(req.op) == OP_SHUTDOWN);
								qsel_d    = Q_EXACT;
								state_d   = S_CLEAR;
							end
						end
					endcase
				end
			end
			S_SCAN: begin
				if (rem_q == '0) begin
					if (qsel_q == Q_LAST_CTX) begin
						state_d = S_FLUSH;
					end else begin
						qsel_d = qnext;
						rem_d  = stat.count[qnext];
					end
				end else if (!stale) begin
					ctl.qop = QOP_ROTATE;
					rem_d   = rem_q - 5'd1;
				end else if (out_free) begin
					ctl.qop = QOP_POP;
					rem_d   = rem_q - 5'd1;
					emit    = 1'b1;
					e_kind  = K_SUPERSEDED;
					e_frame = stat.head.frame;
					e_prio  = qsel_q;
					e_seq   = stat.head.seq;
					e_last  = 1'b0;
				end
			end
			S_FLUSH: begin
				ctl.q = Q_PREFETCH;
				if (prio_q != Q_EXACT || stat.count[Q_PREFETCH] == '0) begin
					state_d = S_DROP;
				end else if (out_free) begin
					ctl.qop = QOP_POP;
					emit    = 1'b1;
					e_kind  = K_SUPERSEDED;
					e_frame = stat.head.frame;
					e_prio  = Q_PREFETCH;
					e_seq   = stat.head.seq;
					e_last  = 1'b0;
				end
			end
			S_DROP: begin
				ctl.q = prio_q;
				if (stat.count[prio_q] < Q_DEPTH[prio_q]) begin
					state_d = S_PUSH;
				end else if (out_free) begin
					ctl.qop = QOP_POP;
					emit    = 1'b1;
					e_kind  = K_SUPERSEDED;
					e_frame = stat.head.frame;
					e_prio  = prio_q;
					e_seq   = stat.head.seq;
					e_last  = 1'b0;
				end
			end
			S_PUSH: begin
				ctl.q = prio_q;
				if (out_free) begin
					ctl.qop = QOP_PUSH;
					emit    = 1'b1;
					e_kind  = K_ACCEPTED;
					e_frame = new_q.frame;
					e_prio  = prio_q;
					e_seq   = new_q.seq;
					state_d = S_IDLE;
				end
			end
			S_CLEAR: begin
				if (stat.count[qsel_q] != '0) begin
					if (out_free) begin
						ctl.qop = QOP_POP;
						emit    = 1'b1;
						e_kind  = K_SUPERSEDED;
						e_frame = stat.head.frame;
						e_prio  = qsel_q;
						e_seq   = stat.head.seq;
						e_last  = 1'b0;
					end
				end else if (qsel_q == Q_ANALYSIS) begin
					state_d = S_DONE;
				end else begin
					qsel_d = qnext;
				end
			end
			S_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state, context and the response slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			qsel_q      <= '0;
			rem_q       <= '0;
			stopped_q   <= 1'b0;
			lat_valid_q <= 1'b0;
			lat_sess_q  <= '0;
			lat_epoch_q <= '0;
			lat_gen_q   <= '0;
			prio_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			qsel_q      <= qsel_d;
			rem_q       <= rem_d;
			stopped_q   <= stopped_d;
			lat_valid_q <= lat_valid_d;
			lat_sess_q  <= lat_sess_d;
			lat_epoch_q <= lat_epoch_d;
			lat_gen_q   <= lat_gen_d;
			prio_q      <= prio_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		new_q <= new_d;
		if (emit) begin
			out_kind_q  <= e_kind;
			out_frame_q <= e_frame;
			out_prio_q  <= e_prio;
			out_seq_q   <= e_seq;
			out_last_q  <= e_last;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.kind           = out_kind_q;
	assign rsp.job_frame      = out_frame_q;
	assign rsp.job_priority   = out_prio_q;
	assign rsp.job_sequential = out_seq_q;
	assign rsp.last           = out_last_q;

`ifndef SYNTHESIS
	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stopped flag cleared");
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("response overwritten");
	a_take_answers: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.op == OP_TAKE |=> rsp.valid && rsp.last)
		else $error("take gave no final response");
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !e_last |-> state_d != S_IDLE)
		else $error("sequence ended without final response");
`endif

endmodule
